// ----- design/lr11_pkg.sv -----
// Package for the linear11 limit rescaler: types, constants and factor tables.
`default_nettype none
package lr11_pkg;

    localparam int WordW   = 16;
    localparam int CmdW    = 2;
    localparam int DecW    = 36;
    localparam int MagW    = 35;
    localparam int ProdW   = 39;
    localparam int NrmW    = 36;
    localparam int DsrW    = 10;
    localparam int RemW    = DsrW + 1;
    localparam int StepBits = 3;
    localparam int DivSteps = ProdW / StepBits;
    localparam int CntW    = $clog2(DivSteps);

    localparam int Milli    = 1000;
    localparam int NormHigh = 1023 * 1000;
    localparam int NormLow  = 511 * 1000;
    localparam int MantMax  = 'h3ff;
    localparam int ExpMax   = 15;
    localparam int ExpMin   = -15;

    localparam logic [CmdW-1:0] CMD_READ_OVER   = 2'd0;
    localparam logic [CmdW-1:0] CMD_READ_UNDER  = 2'd1;
    localparam logic [CmdW-1:0] CMD_WRITE_OVER  = 2'd2;
    localparam logic [CmdW-1:0] CMD_WRITE_UNDER = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCALE,
        ST_DIV1,
        ST_NORM_DOWN,
        ST_NORM_UP,
        ST_DIV2,
        ST_DONE
    } state_t;

    function automatic logic [3:0] mul_factor(input logic [CmdW-1:0] sel);
        logic [3:0] f;
        case (sel)
            CMD_READ_OVER:   f = 4'd9;
            CMD_READ_UNDER:  f = 4'd11;
            CMD_WRITE_OVER:  f = 4'd10;
            CMD_WRITE_UNDER: f = 4'd10;
            default:         f = 4'd10;
        endcase
        return f;
    endfunction

    function automatic logic [3:0] div_factor(input logic [CmdW-1:0] sel);
        logic [3:0] f;
        case (sel)
            CMD_READ_OVER:   f = 4'd10;
            CMD_READ_UNDER:  f = 4'd10;
            CMD_WRITE_OVER:  f = 4'd9;
            CMD_WRITE_UNDER: f = 4'd11;
            default:         f = 4'd10;
        endcase
        return f;
    endfunction

endpackage
`default_nettype wire

// ----- design/lr11_in_if.sv -----
// Input channel interface: valid/ready with cmd and linear word.
`default_nettype none
interface lr11_in_if;
    logic                        valid;
    logic                        ready;
    logic [lr11_pkg::CmdW-1:0]   cmd;
    logic [lr11_pkg::WordW-1:0]  word_in;

    modport source (output valid, output cmd, output word_in, input ready);
    modport sink   (input valid, input cmd, input word_in, output ready);
endinterface
`default_nettype wire

// ----- design/lr11_out_if.sv -----
// Output channel interface: valid/ready with rescaled word and decoded value.
`default_nettype none
interface lr11_out_if;
    logic                              valid;
    logic                              ready;
    logic [lr11_pkg::WordW-1:0]        word_out;
    logic signed [lr11_pkg::DecW-1:0]  decoded_milli;

    modport source (output valid, output word_out, output decoded_milli, input ready);
    modport sink   (input valid, input word_out, input decoded_milli, output ready);
endinterface
`default_nettype wire

// ----- design/linear11_limit_rescaler.sv -----
// Top level: rescales a linear11 limit word by 9/10, 11/10, 10/9 or 10/11.
//
// Channels: sample (sink) carries cmd and word_in; result (source) carries
// word_out and decoded_milli. Each transfer completes when valid and ready
// are both high at a rising clock edge.
// One item at a time: sample.ready is high only while the sequencer is idle.
// After the input transfer the item passes through decode, multiply, the
// shared 3-bit-per-cycle restoring divider for the factor division, a
// normalize-down check and a normalize-up check with one shift per cycle,
// a second divider pass for rounding and the output load; a rescaled value
// of zero skips normalize and rounding. The next item waits for idle.
// A finished result sits in the output register; a new item is accepted
// while it waits. If the receiver stalls, the next result holds in the last
// state until the output register is free.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and drops
// result.valid.
`default_nettype none
module linear11_limit_rescaler (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lr11_in_if.sink    sample,
    lr11_out_if.source result
);
    import lr11_pkg::*;

    state_t state_reg, state_next;

    logic [CntW-1:0]        cnt_reg, cnt_next;
    logic                   out_valid_reg, out_valid_next;

    logic [CmdW-1:0]        sel_reg, sel_next;
    logic [WordW-1:0]       word_reg, word_next;
    logic                   neg_reg, neg_next;
    logic [MagW-1:0]        mag_reg, mag_next;
    logic [DecW-1:0]        dec_reg, dec_next;
    logic [ProdW-1:0]       dvd_reg, dvd_next;
    logic [RemW-1:0]        rem_reg, rem_next;
    logic [DsrW-1:0]        dsr_reg, dsr_next;
    logic signed [4:0]      exp_reg, exp_next;
    logic [NrmW-1:0]        nrm_reg, nrm_next;
    logic [WordW-1:0]       res_reg, res_next;
    logic [WordW-1:0]       out_word_reg, out_word_next;
    logic [DecW-1:0]        out_dec_reg, out_dec_next;

    // decode
    logic [4:0]             dec_e5;
    logic [10:0]            dec_m11;
    logic                   dec_sign;
    logic [10:0]            dec_mabs;
    logic [19:0]            dec_v;
    logic [4:0]             dec_k;
    logic [20:0]            dec_round;
    logic [20:0]            dec_sum;
    logic [MagW-1:0]        dec_mag;
    logic                   dec_neg;

    // shared divider step
    logic [RemW-1:0]        div_rem;
    logic [ProdW-1:0]       div_dvd;
    logic                   div_q;
    logic                   div_last;

    // rounding stage
    logic [10:0]            rnd_q;
    logic [9:0]             rnd_mant;
    logic [10:0]            rnd_m11;

    logic                   accept;
    logic                   out_free;
    logic                   norm_down_go;
    logic                   norm_up_go;
    logic [NrmW-1:0]        scaled;

    assign accept   = sample.valid && sample.ready;
    assign out_free = !out_valid_reg || result.ready;
    assign div_last = (cnt_reg == CntW'(DivSteps - 1));
    assign scaled   = div_dvd[NrmW-1:0];

    assign norm_down_go = (nrm_reg >= NrmW'(NormHigh)) && (exp_reg < 5'(ExpMax));
    assign norm_up_go   = (nrm_reg < NrmW'(NormLow)) && (exp_reg > 5'(ExpMin));

    assign sample.ready         = (state_reg == ST_IDLE);
    assign result.valid         = out_valid_reg;
    assign result.word_out      = out_word_reg;
    assign result.decoded_milli = out_dec_reg;

    always_comb
    begin
        dec_e5    = word_reg[15:11];
        dec_m11   = word_reg[10:0];
        dec_sign  = dec_m11[10];
        dec_mabs  = dec_sign ? (11'd0 - dec_m11) : dec_m11;
        dec_v     = 20'({9'd0, dec_mabs} * 20'(Milli));
        dec_k     = 5'd0 - dec_e5;
        dec_round = dec_sign ? ((21'd1 << dec_k) - 21'd1) : 21'd0;
        dec_sum   = {1'b0, dec_v} + dec_round;
        if (!dec_e5[4])
        begin
            dec_mag = MagW'(dec_v) << dec_e5[3:0];
        end
        else
        begin
            dec_mag = MagW'(dec_sum >> dec_k);
        end
        dec_neg = dec_sign && (dec_mag != '0);
    end

    always_comb
    begin
        div_rem = rem_reg;
        div_dvd = dvd_reg;
        div_q   = 1'b0;
        for (int i = 0; i < StepBits; i++)
        begin
            div_rem = {div_rem[RemW-2:0], div_dvd[ProdW-1]};
            div_q   = (div_rem >= {1'b0, dsr_reg});
            if (div_q)
            begin
                div_rem = div_rem - {1'b0, dsr_reg};
            end
            div_dvd = {div_dvd[ProdW-2:0], div_q};
        end
    end

    always_comb
    begin
        rnd_q    = div_dvd[10:0];
        rnd_mant = (rnd_q > 11'(MantMax)) ? 10'(MantMax) : rnd_q[9:0];
        rnd_m11  = neg_reg ? (11'd0 - {1'b0, rnd_mant}) : {1'b0, rnd_mant};
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:    state_next = ST_SCALE;
            ST_SCALE:     state_next = ST_DIV1;
            ST_DIV1:
            begin
                if (div_last)
                begin
                    state_next = (scaled == '0) ? ST_DONE : ST_NORM_DOWN;
                end
            end
            ST_NORM_DOWN:
            begin
                if (!norm_down_go)
                begin
                    state_next = ST_NORM_UP;
                end
            end
            ST_NORM_UP:
            begin
                if (!norm_up_go)
                begin
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2:
            begin
                if (div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        sel_next       = sel_reg;
        word_next      = word_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        dec_next       = dec_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        dsr_next       = dsr_reg;
        exp_next       = exp_reg;
        nrm_next       = nrm_reg;
        res_next       = res_reg;
        out_word_next  = out_word_reg;
        out_dec_next   = out_dec_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    sel_next  = sample.cmd;
                    word_next = sample.word_in;
                end
            end
            ST_DECODE:
            begin
                neg_next = dec_neg;
                mag_next = dec_mag;
                dec_next = dec_neg ? (DecW'(0) - {1'b0, dec_mag}) : {1'b0, dec_mag};
            end
            ST_SCALE:
            begin
                dvd_next = ProdW'(mag_reg) * ProdW'(mul_factor(sel_reg))
                         + ProdW'(div_factor(sel_reg) >> 1);
                dsr_next = DsrW'(div_factor(sel_reg));
                rem_next = '0;
                cnt_next = '0;
            end
            ST_DIV1:
            begin
                dvd_next = div_dvd;
                rem_next = div_rem;
                cnt_next = cnt_reg + CntW'(1);
                if (div_last)
                begin
                    nrm_next = scaled;
                    exp_next = 5'sd0;
                    res_next = '0;
                end
            end
            ST_NORM_DOWN:
            begin
                if (norm_down_go)
                begin
                    nrm_next = nrm_reg >> 1;
                    exp_next = exp_reg + 5'sd1;
                end
            end
            ST_NORM_UP:
            begin
                if (norm_up_go)
                begin
                    nrm_next = nrm_reg << 1;
                    exp_next = exp_reg - 5'sd1;
                end
                else
                begin
                    dvd_next = ProdW'(nrm_reg[20:0]) + ProdW'(Milli / 2);
                    dsr_next = DsrW'(Milli);
                    rem_next = '0;
                    cnt_next = '0;
                end
            end
            ST_DIV2:
            begin
                dvd_next = div_dvd;
                rem_next = div_rem;
                cnt_next = cnt_reg + CntW'(1);
                if (div_last)
                begin
                    res_next = {exp_reg, rnd_m11};
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = res_reg;
                    out_dec_next   = dec_reg;
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg      <= sel_next;
        word_reg     <= word_next;
        neg_reg      <= neg_next;
        mag_reg      <= mag_next;
        dec_reg      <= dec_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        dsr_reg      <= dsr_next;
        exp_reg      <= exp_next;
        nrm_reg      <= nrm_next;
        res_reg      <= res_next;
        out_word_reg <= out_word_next;
        out_dec_reg  <= out_dec_next;
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_DECODE))
        else $error("accepted transfer did not start decode");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV1 || state_reg == ST_DIV2) |-> (rem_reg < {1'b0, dsr_reg}))
        else $error("divider remainder out of range");

    a_exp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NORM_DOWN || state_reg == ST_NORM_UP || state_reg == ST_DIV2)
        |-> (exp_reg <= 5'(ExpMax) && exp_reg >= 5'(ExpMin)))
        else $error("exponent left clamp range");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && !result.ready) |=> (state_reg == ST_DONE))
        else $error("result dropped while output stalled");

endmodule
`default_nettype wire
